// ===== sv/mgrk4_pkg.sv =====
package mgrk4_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS  = 28;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 29;
    localparam int EXP_W      = 5;
    localparam int CFG_ADDR_W = 2;

    // Internal arithmetic widths
    localparam int WIDE_W = 72;
    localparam int MUL_W  = 36;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = ((FRAC_BITS > 31) ? FRAC_BITS : 31) + 3;
    localparam int QUO_W  = 32;
    localparam int CMP_W  = ((QUO_W + DEN_W > NUM_W) ? QUO_W + DEN_W : NUM_W) + 1;

    // Power chain: exponent n needs n-1 multiplies, largest n is 2^EXP_W - 1
    localparam int POW_STAGES = (1 << EXP_W) - 2;

    // RK4 sum and divide-by-six
    localparam int          SUM_W       = 35;
    localparam int          DIV6_N_W    = SUM_W - 1;
    localparam int          DIV3_SHIFT  = 32;
    localparam logic [31:0] DIV3_M      = 32'h5555_5555;
    localparam int          REM3_W      = 4;

    // Register reset values
    localparam logic [COEF_W-1:0] RST_GAIN_A    = 29'd53687091;
    localparam logic [COEF_W-1:0] RST_DECAY_B   = 29'd26843546;
    localparam logic [COEF_W-1:0] RST_TIME_STEP = 29'd26843546;
    localparam logic [EXP_W-1:0]  RST_EXPONENT  = 5'd10;

    localparam logic signed [WIDE_W-1:0] ONE_W   = {{(WIDE_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] MAX32_W = 72'sd2147483647;
    localparam logic signed [WIDE_W-1:0] MIN32_W = -72'sd2147483648;
    localparam logic signed [DATA_W-1:0] MAX32   = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] MIN32   = 32'sh8000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_A    = 2'd0,
        CFG_DECAY_B   = 2'd1,
        CFG_TIME_STEP = 2'd2,
        CFG_EXPONENT  = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic [COEF_W-1:0] gain_a;
        logic [COEF_W-1:0] decay_b;
        logic [COEF_W-1:0] time_step;
        logic [EXP_W-1:0]  exponent;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_now;
        logic signed [DATA_W-1:0] x_delayed;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_next;
        logic                     saturated;
    } t_out;

    // Power chain to divider
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [NUM_W-1:0]  num;
        logic signed [DATA_W-1:0] pw;
        logic                     clip;
    } t_term_req;

    // Divider to RK stages
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] term;
        logic                     clip;
    } t_rk_req;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Clip to signed 32-bit range
    function automatic t_sat sat32(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        if (v > MAX32_W) begin
            r.clip = 1'b1;
            r.val  = MAX32;
        end else if (v < MIN32_W) begin
            r.clip = 1'b1;
            r.val  = MIN32;
        end else begin
            r.clip = 1'b0;
            r.val  = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Shift right with round to nearest, ties away from zero
    function automatic logic signed [WIDE_W-1:0] round_shr(input logic signed [WIDE_W-1:0] v,
                                                           input int unsigned s);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] half;
        half = {{(WIDE_W-1){1'b0}}, 1'b1} << (s - 1);
        m    = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        m    = (m + half) >> s;
        return v[WIDE_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // Fixed-point product, rounded back to FRAC_BITS
    function automatic logic signed [WIDE_W-1:0] mulq(input logic signed [MUL_W-1:0] a,
                                                      input logic signed [MUL_W-1:0] b);
        logic signed [WIDE_W-1:0] p;
        p = WIDE_W'(a) * WIDE_W'(b);
        return round_shr(p, FRAC_BITS);
    endfunction

    function automatic logic signed [MUL_W-1:0] coef_ext(input logic [COEF_W-1:0] c);
        return MUL_W'($signed({1'b0, c}));
    endfunction

endpackage

// ===== sv/mgrk4_power.sv =====
module mgrk4_power (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  mgrk4_pkg::t_cfg        i_cfg,
    input  logic                   i_valid,
    input  mgrk4_pkg::t_in         i_data,
    output logic                   o_valid,
    output mgrk4_pkg::t_term_req   o_data
);

    localparam int NS = mgrk4_pkg::POW_STAGES;

    logic                                r_vld  [0:NS];
    logic signed [mgrk4_pkg::DATA_W-1:0] r_x    [0:NS];
    logic signed [mgrk4_pkg::DATA_W-1:0] r_xd   [0:NS];
    logic signed [mgrk4_pkg::DATA_W-1:0] r_p    [0:NS];
    logic signed [mgrk4_pkg::NUM_W-1:0]  r_num  [0:NS];
    logic                                r_clip [0:NS];

    mgrk4_pkg::t_sat                     w_one;
    logic signed [mgrk4_pkg::WIDE_W-1:0] w_num;
    logic signed [mgrk4_pkg::DATA_W-1:0] n_p0;
    logic                                n_clip0;

    // Entry: numerator a*xd and starting power
    always_comb begin
        w_one = mgrk4_pkg::sat32(mgrk4_pkg::ONE_W);
        w_num = mgrk4_pkg::WIDE_W'($signed({1'b0, i_cfg.gain_a}))
              * mgrk4_pkg::WIDE_W'(i_data.x_delayed);
        if (i_cfg.exponent == '0) begin
            n_p0    = w_one.val;
            n_clip0 = w_one.clip;
        end else begin
            n_p0    = i_data.x_delayed;
            n_clip0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_data.x_now;
            r_xd[0]   <= i_data.x_delayed;
            r_p[0]    <= n_p0;
            r_num[0]  <= w_num[mgrk4_pkg::NUM_W-1:0];
            r_clip[0] <= n_clip0;
        end
    end

    // One saturating multiply per stage; stages past n-1 pass through
    for (genvar s = 0; s < NS; s++) begin : g_pow
        mgrk4_pkg::t_sat w_m;
        logic            w_apply;

        assign w_apply = (mgrk4_pkg::EXP_W'(s + 1) < i_cfg.exponent);
        assign w_m     = mgrk4_pkg::sat32(mgrk4_pkg::mulq(mgrk4_pkg::MUL_W'(r_p[s]),
                                                          mgrk4_pkg::MUL_W'(r_xd[s])));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]    <= r_x[s];
                r_xd[s+1]   <= r_xd[s];
                r_num[s+1]  <= r_num[s];
                r_p[s+1]    <= w_apply ? w_m.val : r_p[s];
                r_clip[s+1] <= r_clip[s] | (w_apply & w_m.clip);
            end
        end
    end

    assign o_valid     = r_vld[NS];
    assign o_data.x    = r_x[NS];
    assign o_data.num  = r_num[NS];
    assign o_data.pw   = r_p[NS];
    assign o_data.clip = r_clip[NS];

endmodule

// ===== sv/mgrk4_div.sv =====
module mgrk4_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  mgrk4_pkg::t_term_req  i_data,
    output logic                  o_valid,
    output mgrk4_pkg::t_rk_req    o_data
);

    localparam int QW = mgrk4_pkg::QUO_W;
    localparam int CW = mgrk4_pkg::CMP_W;
    localparam int DW = mgrk4_pkg::DEN_W;

    logic                                r_vld  [0:QW];
    logic [CW-1:0]                       r_rem  [0:QW];
    logic [QW-1:0]                       r_q    [0:QW];
    logic [DW-1:0]                       r_d    [0:QW];
    logic                                r_neg  [0:QW];
    logic                                r_zero [0:QW];
    logic                                r_ovf  [0:QW];
    logic                                r_nsgn [0:QW];
    logic                                r_nnz  [0:QW];
    logic signed [mgrk4_pkg::DATA_W-1:0] r_x    [0:QW];
    logic                                r_clip [0:QW];

    logic                                r_out_vld;
    mgrk4_pkg::t_rk_req                  r_out;

    logic signed [mgrk4_pkg::WIDE_W-1:0] w_den;
    logic [mgrk4_pkg::WIDE_W-1:0]        w_den_abs;
    logic [DW-1:0]                       w_d;
    logic [mgrk4_pkg::NUM_W-1:0]         w_n_abs;
    logic [mgrk4_pkg::NUM_W-1:0]         w_n;
    logic                                w_ovf;

    // Setup: magnitudes, rounding bias, quotient overflow check
    always_comb begin
        w_den     = mgrk4_pkg::ONE_W + mgrk4_pkg::WIDE_W'(i_data.pw);
        w_den_abs = w_den[mgrk4_pkg::WIDE_W-1] ? mgrk4_pkg::WIDE_W'(-w_den)
                                               : mgrk4_pkg::WIDE_W'(w_den);
        w_d       = w_den_abs[DW-1:0];
        w_n_abs   = i_data.num[mgrk4_pkg::NUM_W-1] ? mgrk4_pkg::NUM_W'(-i_data.num)
                                                   : mgrk4_pkg::NUM_W'(i_data.num);
        w_n       = w_n_abs + mgrk4_pkg::NUM_W'(w_d >> 1);
        w_ovf     = (CW'(w_n) >= (CW'(w_d) << QW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= CW'(w_n);
            r_q[0]    <= '0;
            r_d[0]    <= w_d;
            r_neg[0]  <= i_data.num[mgrk4_pkg::NUM_W-1] ^ w_den[mgrk4_pkg::WIDE_W-1];
            r_zero[0] <= (w_den == '0);
            r_ovf[0]  <= w_ovf;
            r_nsgn[0] <= i_data.num[mgrk4_pkg::NUM_W-1];
            r_nnz[0]  <= (i_data.num != '0);
            r_x[0]    <= i_data.x;
            r_clip[0] <= i_data.clip;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar j = 0; j < QW; j++) begin : g_bit
        localparam int B = QW - 1 - j;
        logic [CW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = CW'(r_d[j]) << B;
        assign w_ge = (r_rem[j] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_ge ? (r_rem[j] - w_sh) : r_rem[j];
                r_q[j+1]    <= r_q[j] | (w_ge ? (QW'(1) << B) : '0);
                r_d[j+1]    <= r_d[j];
                r_neg[j+1]  <= r_neg[j];
                r_zero[j+1] <= r_zero[j];
                r_ovf[j+1]  <= r_ovf[j];
                r_nsgn[j+1] <= r_nsgn[j];
                r_nnz[j+1]  <= r_nnz[j];
                r_x[j+1]    <= r_x[j];
                r_clip[j+1] <= r_clip[j];
            end
        end
    end

    // Sign, saturation and the zero-denominator case
    mgrk4_pkg::t_sat                     w_qs;
    logic signed [mgrk4_pkg::WIDE_W-1:0] w_qmag;
    logic signed [mgrk4_pkg::DATA_W-1:0] n_term;
    logic                                n_tclip;

    always_comb begin
        w_qmag = $signed(mgrk4_pkg::WIDE_W'(r_q[QW]));
        w_qs   = mgrk4_pkg::sat32(r_neg[QW] ? -w_qmag : w_qmag);
        if (r_zero[QW]) begin
            n_tclip = r_nnz[QW];
            if (!r_nnz[QW]) begin
                n_term = '0;
            end else begin
                n_term = r_nsgn[QW] ? mgrk4_pkg::MIN32 : mgrk4_pkg::MAX32;
            end
        end else if (r_ovf[QW]) begin
            n_tclip = 1'b1;
            n_term  = r_neg[QW] ? mgrk4_pkg::MIN32 : mgrk4_pkg::MAX32;
        end else begin
            n_tclip = w_qs.clip;
            n_term  = w_qs.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x    <= r_x[QW];
            r_out.term <= n_term;
            r_out.clip <= r_clip[QW] | n_tclip;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== sv/mgrk4_rk.sv =====
module mgrk4_rk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mgrk4_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  mgrk4_pkg::t_rk_req  i_data,
    output logic                o_valid,
    output mgrk4_pkg::t_out     o_data
);

    localparam int DW = mgrk4_pkg::DATA_W;
    localparam int SW = mgrk4_pkg::SUM_W;
    localparam int NW = mgrk4_pkg::DIV6_N_W;
    localparam int PW = NW + mgrk4_pkg::DIV3_SHIFT;
    localparam int WW = mgrk4_pkg::WIDE_W;

    // Per-lane stage registers: A slope, B k, C sum and next argument
    logic                 r_a_vld  [0:3];
    logic signed [DW-1:0] r_a_t    [0:3];
    logic signed [DW-1:0] r_a_x    [0:3];
    logic signed [DW-1:0] r_a_term [0:3];
    logic signed [SW-1:0] r_a_sum  [0:3];
    logic                 r_a_clip [0:3];

    logic                 r_b_vld  [0:3];
    logic signed [DW-1:0] r_b_k    [0:3];
    logic signed [DW-1:0] r_b_x    [0:3];
    logic signed [DW-1:0] r_b_term [0:3];
    logic signed [SW-1:0] r_b_sum  [0:3];
    logic                 r_b_clip [0:3];

    logic                 r_c_vld  [0:3];
    logic signed [DW-1:0] r_c_x    [0:3];
    logic signed [SW-1:0] r_c_sum  [0:3];
    logic                 r_c_clip [0:3];
    logic signed [DW-1:0] r_c_term [0:2];
    logic signed [DW-1:0] r_c_arg  [0:2];

    for (genvar m = 0; m < 4; m++) begin : g_lane
        localparam bit DBL = (m == 1) || (m == 2);

        logic                 w_vin;
        logic signed [DW-1:0] w_arg;
        logic signed [DW-1:0] w_x;
        logic signed [DW-1:0] w_term;
        logic signed [SW-1:0] w_sum;
        logic                 w_clip;
        mgrk4_pkg::t_sat      w_t;
        mgrk4_pkg::t_sat      w_k;
        logic signed [SW-1:0] w_kw;

        if (m == 0) begin : g_first
            assign w_vin  = i_valid;
            assign w_arg  = i_data.x;
            assign w_x    = i_data.x;
            assign w_term = i_data.term;
            assign w_sum  = '0;
            assign w_clip = i_data.clip;
        end else begin : g_next
            assign w_vin  = r_c_vld[m-1];
            assign w_arg  = r_c_arg[m-1];
            assign w_x    = r_c_x[m-1];
            assign w_term = r_c_term[m-1];
            assign w_sum  = r_c_sum[m-1];
            assign w_clip = r_c_clip[m-1];
        end

        // Slope: term - b*arg
        assign w_t = mgrk4_pkg::sat32(WW'(w_term)
                   - mgrk4_pkg::mulq(mgrk4_pkg::coef_ext(i_cfg.decay_b),
                                     mgrk4_pkg::MUL_W'(w_arg)));
        // k = h*slope
        assign w_k = mgrk4_pkg::sat32(mgrk4_pkg::mulq(mgrk4_pkg::coef_ext(i_cfg.time_step),
                                                      mgrk4_pkg::MUL_W'(r_a_t[m])));
        // Weighted k into the running sum
        assign w_kw = DBL ? (SW'(r_b_k[m]) <<< 1) : SW'(r_b_k[m]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[m] <= 1'b0;
                r_b_vld[m] <= 1'b0;
                r_c_vld[m] <= 1'b0;
            end else if (i_en) begin
                r_a_vld[m] <= w_vin;
                r_b_vld[m] <= r_a_vld[m];
                r_c_vld[m] <= r_b_vld[m];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_t[m]    <= w_t.val;
                r_a_x[m]    <= w_x;
                r_a_term[m] <= w_term;
                r_a_sum[m]  <= w_sum;
                r_a_clip[m] <= w_clip | w_t.clip;

                r_b_k[m]    <= w_k.val;
                r_b_x[m]    <= r_a_x[m];
                r_b_term[m] <= r_a_term[m];
                r_b_sum[m]  <= r_a_sum[m];
                r_b_clip[m] <= r_a_clip[m] | w_k.clip;

                r_c_x[m]    <= r_b_x[m];
                r_c_sum[m]  <= r_b_sum[m] + w_kw;
            end
        end

        if (m < 3) begin : g_arg
            logic signed [WW-1:0] w_adj;
            mgrk4_pkg::t_sat      w_a;

            // Stage argument: x + k/2, or x + k before the last stage
            assign w_adj = (m == 2) ? WW'(r_b_k[m]) : mgrk4_pkg::round_shr(WW'(r_b_k[m]), 1);
            assign w_a   = mgrk4_pkg::sat32(WW'(r_b_x[m]) + w_adj);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c_arg[m]  <= w_a.val;
                    r_c_term[m] <= r_b_term[m];
                    r_c_clip[m] <= r_b_clip[m] | w_a.clip;
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c_clip[m] <= r_b_clip[m];
                end
            end
        end
    end

    // Divide the sum by six: |sum|+3, halve, then divide by 3 via reciprocal
    logic                 r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;
    logic                 r_f1_neg, r_f2_neg, r_f3_neg;
    logic [NW-1:0]        r_f1_n, r_f2_n;
    logic [NW-1:0]        r_f2_q0, r_f3_q0;
    logic [mgrk4_pkg::REM3_W-1:0] r_f3_r;
    logic signed [DW-1:0] r_f1_x, r_f2_x, r_f3_x;
    logic                 r_f1_clip, r_f2_clip, r_f3_clip;
    mgrk4_pkg::t_out      r_f4_out;

    logic [SW-1:0]        w_mag;
    logic [SW-1:0]        w_v;
    logic [PW-1:0]        w_prod;
    logic [NW-1:0]        w_rw;
    logic [NW-1:0]        w_corr;
    logic [NW-1:0]        w_q;
    logic signed [WW-1:0] w_qs;
    mgrk4_pkg::t_sat      w_res;

    always_comb begin
        w_mag  = r_c_sum[3][SW-1] ? SW'(-r_c_sum[3]) : SW'(r_c_sum[3]);
        w_v    = w_mag + SW'(3);
        w_prod = PW'(r_f1_n) * PW'(mgrk4_pkg::DIV3_M);
        w_rw   = r_f2_n - ((r_f2_q0 << 1) + r_f2_q0);
        if (r_f3_r >= mgrk4_pkg::REM3_W'(6)) begin
            w_corr = NW'(2);
        end else if (r_f3_r >= mgrk4_pkg::REM3_W'(3)) begin
            w_corr = NW'(1);
        end else begin
            w_corr = '0;
        end
        w_q   = r_f3_q0 + w_corr;
        w_qs  = $signed(WW'(w_q));
        w_res = mgrk4_pkg::sat32(WW'(r_f3_x) + (r_f3_neg ? -w_qs : w_qs));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
        end else if (i_en) begin
            r_f1_vld <= r_c_vld[3];
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_neg  <= r_c_sum[3][SW-1];
            r_f1_n    <= w_v[SW-1:1];
            r_f1_x    <= r_c_x[3];
            r_f1_clip <= r_c_clip[3];

            r_f2_neg  <= r_f1_neg;
            r_f2_n    <= r_f1_n;
            r_f2_q0   <= w_prod[PW-1:mgrk4_pkg::DIV3_SHIFT];
            r_f2_x    <= r_f1_x;
            r_f2_clip <= r_f1_clip;

            r_f3_neg  <= r_f2_neg;
            r_f3_q0   <= r_f2_q0;
            r_f3_r    <= w_rw[mgrk4_pkg::REM3_W-1:0];
            r_f3_x    <= r_f2_x;
            r_f3_clip <= r_f2_clip;

            r_f4_out.x_next    <= w_res.val;
            r_f4_out.saturated <= r_f3_clip | w_res.clip;
        end
    end

    assign o_valid = r_f4_vld;
    assign o_data  = r_f4_out;

endmodule

// ===== sv/mackey_glass_rk4_step.sv =====
// Mackey-Glass RK4 step: x_next = one fourth-order Runge-Kutta step of
// dx/dt = -b*x + a*xd/(1 + xd^n), fixed point with 28 fraction bits.
//
// Input channel: i_in_valid / o_in_stall / i_in_data (x_now, x_delayed).
// Output channel: o_out_valid / i_out_stall / o_out_data (x_next, saturated).
// A transaction happens on a rising edge where valid is high and stall is low.
// Configuration: i_cfg_we / i_cfg_addr / i_cfg_wdata, to be written only while
// idle; this binds the user, the block itself does not enforce it.
// Throughput: one transaction per cycle while o_in_stall is low. From the
// accepting edge to o_out_valid a transaction passes an entry register, 30
// power-multiply stages, 34 divider stages (setup, one per quotient bit and
// result), 16 RK4 and final-divide stages and the output register.
//
// Reset empties the pipeline and loads a=0.2, b=0.1, h=0.1, n=10.
// When the receiver stalls, the output register holds its transaction and a
// one-entry skid buffer catches the next one; the pipeline then freezes and
// o_in_stall rises until the skid buffer drains. Nothing is dropped.
module mackey_glass_rk4_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mgrk4_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [mgrk4_pkg::COEF_W-1:0]          i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mgrk4_pkg::t_in                        i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mgrk4_pkg::t_out                       o_out_data
);

    mgrk4_pkg::t_cfg      r_cfg;

    logic                 w_en;
    logic                 w_pow_vld;
    mgrk4_pkg::t_term_req w_pow_data;
    logic                 w_div_vld;
    mgrk4_pkg::t_rk_req   w_div_data;
    logic                 w_pvld;
    mgrk4_pkg::t_out      w_pdata;

    logic                 r_ov, n_ov;
    logic                 r_sv, n_sv;
    mgrk4_pkg::t_out      r_od, n_od;
    mgrk4_pkg::t_out      r_sd, n_sd;
    logic                 w_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_a    <= mgrk4_pkg::RST_GAIN_A;
            r_cfg.decay_b   <= mgrk4_pkg::RST_DECAY_B;
            r_cfg.time_step <= mgrk4_pkg::RST_TIME_STEP;
            r_cfg.exponent  <= mgrk4_pkg::RST_EXPONENT;
        end else if (i_cfg_we) begin
            unique case (mgrk4_pkg::t_cfg_addr'(i_cfg_addr))
                mgrk4_pkg::CFG_GAIN_A:    r_cfg.gain_a    <= i_cfg_wdata;
                mgrk4_pkg::CFG_DECAY_B:   r_cfg.decay_b   <= i_cfg_wdata;
                mgrk4_pkg::CFG_TIME_STEP: r_cfg.time_step <= i_cfg_wdata;
                mgrk4_pkg::CFG_EXPONENT:  r_cfg.exponent  <= i_cfg_wdata[mgrk4_pkg::EXP_W-1:0];
            endcase
        end
    end

    // Pipeline advances whenever the skid buffer is empty
    assign w_en       = !r_sv;
    assign o_in_stall = r_sv;

    mgrk4_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_pow_vld),
        .o_data  (w_pow_data)
    );

    mgrk4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pow_vld),
        .i_data  (w_pow_data),
        .o_valid (w_div_vld),
        .o_data  (w_div_data)
    );

    mgrk4_rk u_rk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_div_vld),
        .i_data  (w_div_data),
        .o_valid (w_pvld),
        .o_data  (w_pdata)
    );

    // Output register with skid buffer
    always_comb begin
        n_ov   = r_ov;
        n_od   = r_od;
        n_sv   = r_sv;
        n_sd   = r_sd;
        w_take = w_en && w_pvld;
        if (!r_ov || !i_out_stall) begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = 1'b0;
            end else begin
                n_ov = w_take;
                n_od = w_pdata;
            end
        end else if (w_take) begin
            n_sv = 1'b1;
            n_sd = w_pdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    // Skid entry only ever sits behind a held output transaction
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid buffer full while output register empty");

    // Skid fills only when the output was held by the receiver
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && i_out_stall))
        else $error("skid buffer filled without a receiver stall");

    // Skid drains into the output as soon as the receiver takes the output
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_out_stall) |=> (!r_sv && r_ov))
        else $error("skid buffer did not drain");

    // Reset empties both output stages
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_ov && !r_sv))
        else $error("output stages not cleared by reset");

endmodule
